### rtl/core/cma_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cma_pkg
// Shared types and constants for the centred moving average block.
// ----------------------------------------------------------------------------
package cma_pkg;

    localparam int SAMPLE_BITS     = 24;
    localparam int RADIUS_BITS     = 5;
    localparam int MAX_RADIUS_DEF  = 31;
    localparam int MAX_OUT         = 32;
    localparam int SENT_BITS       = 7;
    localparam int DIV_STEPS       = 4;
    localparam int QUEUE_DEPTH     = 4;
    localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = RADIUS_BITS'(1);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          final_sample;
    } cma_in_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] average;
        logic                          run_last;
        logic                          sequence_end;
    } cma_out_t;

    typedef struct packed {
        logic full;
        logic empty;
    } cma_q_status_t;

    typedef enum logic [2:0] {
        FR_IDLE,
        FR_TRIM,
        FR_TRIM_DROP,
        FR_WRITE,
        FR_DECIDE,
        FR_PUSH,
        FR_CHECK,
        FR_FLUSH_DROP
    } cma_front_state_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_DONE
    } cma_back_state_t;

endpackage
`default_nettype wire

### rtl/core/cma_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cma_front
// Accepts sample words, keeps the window store and running sum, and queues
// one divide job (sum, count, flags) for every average to be produced.
// ----------------------------------------------------------------------------
module cma_front
    import cma_pkg::*;
#(
    parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic [RADIUS_BITS-1:0] radius,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire cma_in_t                s_data,
    input  wire cma_q_status_t          q_status,
    output logic                        push,
    output logic [SAMPLE_BITS+$clog2(2*MAX_RADIUS+2)-1:0] push_sum,
    output logic [$clog2(2*MAX_RADIUS+2)-1:0]            push_count,
    output logic                        push_last,
    output logic                        push_end
);

    localparam int CNT_W   = $clog2(2*MAX_RADIUS+2);
    localparam int SUM_W   = SAMPLE_BITS + CNT_W;
    localparam int ADDR_W  = $clog2(2*MAX_RADIUS+1);
    localparam int DEPTH   = 1 << ADDR_W;
    localparam int RAD_W   = $clog2(MAX_RADIUS+1);
    localparam int CMP_W   = (RAD_W > RADIUS_BITS) ? RAD_W : RADIUS_BITS;
    localparam int PCMP_W  = CNT_W + 6;

    cma_front_state_t state_reg, state_next;

    logic signed [SAMPLE_BITS-1:0] mem [DEPTH];
    logic signed [SAMPLE_BITS-1:0] rd_data_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic                          fin_reg, fin_next;
    logic signed [SUM_W-1:0]       sum_reg, sum_next;
    logic [CNT_W-1:0]              seen_reg, seen_next;
    logic [SENT_BITS-1:0]          sent_reg, sent_next;
    logic [ADDR_W-1:0]             slot_reg, slot_next;
    logic [CNT_W-1:0]              k_reg, k_next;
    logic [CNT_W-1:0]              pend_reg, pend_next;

    logic [RAD_W-1:0]  m_eff;
    logic [CNT_W-1:0]  win;
    logic [ADDR_W-1:0] rd_addr;
    logic              mem_we;
    logic              need_trim;
    logic              need_drop;
    logic              is_last;
    logic [CNT_W-1:0]  pend_calc;
    logic [PCMP_W-1:0] pend_wide;
    logic signed [SUM_W-1:0] sample_ext;
    logic signed [SUM_W-1:0] rd_ext;

    // effective radius and window
    always_comb begin
        if (CMP_W'(radius) > CMP_W'(MAX_RADIUS)) begin
            m_eff = RAD_W'(MAX_RADIUS);
        end else begin
            m_eff = RAD_W'(radius);
        end
        win = CNT_W'({m_eff, 1'b1});
    end

    assign rd_addr    = slot_reg - ADDR_W'(seen_reg);
    assign sample_ext = SUM_W'(sample_reg);
    assign rd_ext     = SUM_W'(rd_data_reg);
    assign need_trim  = (seen_reg >= win) && (seen_reg != '0);
    assign need_drop  = (sent_reg > SENT_BITS'(m_eff)) && (seen_reg > CNT_W'(1));
    assign is_last    = (k_reg + CNT_W'(1)) == pend_reg;

    // flush length: min(held, radius + 1, output limit)
    always_comb begin
        pend_wide = PCMP_W'(seen_reg);
        if (PCMP_W'(m_eff) + PCMP_W'(1) < pend_wide) begin
            pend_wide = PCMP_W'(m_eff) + PCMP_W'(1);
        end
        if (PCMP_W'(MAX_OUT) < pend_wide) begin
            pend_wide = PCMP_W'(MAX_OUT);
        end
        pend_calc = CNT_W'(pend_wide);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            FR_IDLE: begin
                if (s_valid) begin
                    state_next = FR_TRIM;
                end
            end
            FR_TRIM: begin
                state_next = need_trim ? FR_TRIM_DROP : FR_WRITE;
            end
            FR_TRIM_DROP: begin
                state_next = FR_TRIM;
            end
            FR_WRITE: begin
                state_next = FR_DECIDE;
            end
            FR_DECIDE: begin
                if (fin_reg || (seen_reg > CNT_W'(m_eff))) begin
                    state_next = FR_PUSH;
                end else begin
                    state_next = FR_IDLE;
                end
            end
            FR_PUSH: begin
                if (!q_status.full) begin
                    state_next = is_last ? FR_IDLE : FR_CHECK;
                end
            end
            FR_CHECK: begin
                state_next = need_drop ? FR_FLUSH_DROP : FR_PUSH;
            end
            FR_FLUSH_DROP: begin
                state_next = FR_PUSH;
            end
            default: begin
                state_next = FR_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        s_ready    = (state_reg == FR_IDLE);
        mem_we     = (state_reg == FR_WRITE);
        push       = (state_reg == FR_PUSH) && !q_status.full;
        push_sum   = sum_reg;
        push_count = seen_reg;
        push_last  = is_last;
        push_end   = is_last && fin_reg;
    end

    // datapath
    always_comb begin
        sample_next = sample_reg;
        fin_next    = fin_reg;
        sum_next    = sum_reg;
        seen_next   = seen_reg;
        sent_next   = sent_reg;
        slot_next   = slot_reg;
        k_next      = k_reg;
        pend_next   = pend_reg;
        case (state_reg)
            FR_IDLE: begin
                sample_next = s_data.sample;
                fin_next    = s_data.final_sample;
            end
            FR_TRIM_DROP, FR_FLUSH_DROP: begin
                sum_next  = sum_reg - rd_ext;
                seen_next = seen_reg - CNT_W'(1);
            end
            FR_WRITE: begin
                sum_next  = sum_reg + sample_ext;
                seen_next = seen_reg + CNT_W'(1);
                slot_next = slot_reg + ADDR_W'(1);
            end
            FR_DECIDE: begin
                k_next    = '0;
                pend_next = fin_reg ? pend_calc : CNT_W'(1);
            end
            FR_PUSH: begin
                if (!q_status.full) begin
                    if (sent_reg != {SENT_BITS{1'b1}}) begin
                        sent_next = sent_reg + SENT_BITS'(1);
                    end
                    k_next = k_reg + CNT_W'(1);
                    if (is_last && fin_reg) begin
                        sum_next  = '0;
                        seen_next = '0;
                        sent_next = '0;
                        slot_next = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // window store
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[slot_reg] <= sample_reg;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FR_IDLE;
            sum_reg   <= '0;
            seen_reg  <= '0;
            sent_reg  <= '0;
            slot_reg  <= '0;
            k_reg     <= '0;
            pend_reg  <= '0;
        end else begin
            state_reg <= state_next;
            sum_reg   <= sum_next;
            seen_reg  <= seen_next;
            sent_reg  <= sent_next;
            slot_reg  <= slot_next;
            k_reg     <= k_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        sample_reg <= sample_next;
        fin_reg    <= fin_next;
    end

endmodule
`default_nettype wire

### rtl/core/cma_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cma_queue
// Small first-in first-out queue of divide jobs between front and back.
// ----------------------------------------------------------------------------
module cma_queue
    import cma_pkg::*;
#(
    parameter int DATA_W = 32,
    parameter int DEPTH  = QUEUE_DEPTH
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] push_data,
    input  wire logic              pop,
    output logic [DATA_W-1:0]      pop_data,
    output cma_q_status_t          status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    assign pop_data     = entry_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

### rtl/core/cma_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cma_back
// Rounded signed division of a window sum by its count, a few quotient
// bits per cycle, into the result output register.
// ----------------------------------------------------------------------------
module cma_back
    import cma_pkg::*;
#(
    parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire cma_q_status_t         q_status,
    input  wire logic [SAMPLE_BITS+$clog2(2*MAX_RADIUS+2)-1:0] job_sum,
    input  wire logic [$clog2(2*MAX_RADIUS+2)-1:0]            job_count,
    input  wire logic                  job_last,
    input  wire logic                  job_end,
    output logic                       pop,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output cma_out_t                   m_data
);

    localparam int CNT_W   = $clog2(2*MAX_RADIUS+2);
    localparam int SUM_W   = SAMPLE_BITS + CNT_W;
    localparam int DIV_W   = ((SUM_W + DIV_STEPS - 1) / DIV_STEPS) * DIV_STEPS;
    localparam int DIV_CYC = DIV_W / DIV_STEPS;
    localparam int STEP_W  = $clog2(DIV_CYC + 1);

    cma_back_state_t state_reg, state_next;

    logic [DIV_W-1:0]  dvd_reg, dvd_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  div_reg, div_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              neg_reg, neg_next;
    logic              last_reg, last_next;
    logic              end_reg, end_next;
    logic              m_valid_reg, m_valid_next;
    cma_out_t          m_data_reg, m_data_next;

    logic [SUM_W-1:0]  mag;
    logic [DIV_W-1:0]  dvd_step;
    logic [CNT_W-1:0]  rem_step;
    logic              div_done;
    logic              out_free;
    logic              load_out;
    logic [SAMPLE_BITS-1:0] quot;

    assign mag      = job_sum[SUM_W-1] ? (~job_sum + SUM_W'(1)) : job_sum;
    assign div_done = (step_reg == STEP_W'(DIV_CYC - 1));
    assign out_free = !m_valid_reg || m_ready;
    assign quot     = dvd_reg[SAMPLE_BITS-1:0];

    // restoring division, several quotient bits per cycle
    always_comb begin
        logic [CNT_W:0]   trial;
        logic [CNT_W-1:0] r;
        logic [DIV_W-1:0] d;
        r = rem_reg;
        d = dvd_reg;
        for (int i = 0; i < DIV_STEPS; i++) begin
            trial = {r, d[DIV_W-1]};
            d     = {d[DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, div_reg}) begin
                r    = CNT_W'(trial - {1'b0, div_reg});
                d[0] = 1'b1;
            end else begin
                r = trial[CNT_W-1:0];
            end
        end
        rem_step = r;
        dvd_step = d;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (!q_status.empty) begin
                    state_next = BK_DIV;
                end
            end
            BK_DIV: begin
                if (div_done) begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE: begin
                if (out_free) begin
                    state_next = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        pop      = (state_reg == BK_IDLE) && !q_status.empty;
        load_out = (state_reg == BK_DONE) && out_free;
        m_valid  = m_valid_reg;
        m_data   = m_data_reg;
    end

    // datapath
    always_comb begin
        dvd_next     = dvd_reg;
        rem_next     = rem_reg;
        div_next     = div_reg;
        step_next    = step_reg;
        neg_next     = neg_reg;
        last_next    = last_reg;
        end_next     = end_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (pop) begin
            neg_next  = job_sum[SUM_W-1];
            dvd_next  = DIV_W'(mag) + DIV_W'(job_count >> 1);
            rem_next  = '0;
            div_next  = job_count;
            step_next = '0;
            last_next = job_last;
            end_next  = job_end;
        end
        if (state_reg == BK_DIV) begin
            dvd_next  = dvd_step;
            rem_next  = rem_step;
            step_next = step_reg + STEP_W'(1);
        end
        if (load_out) begin
            m_valid_next              = 1'b1;
            m_data_next.average       = neg_reg ? (~quot + SAMPLE_BITS'(1)) : quot;
            m_data_next.run_last      = last_reg;
            m_data_next.sequence_end  = end_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            m_valid_reg <= 1'b0;
            step_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            step_reg    <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        div_reg    <= div_next;
        neg_reg    <= neg_next;
        last_reg   <= last_next;
        end_reg    <= end_next;
        m_data_reg <= m_data_next;
    end

endmodule
`default_nettype wire

### rtl/core/centered_moving_average.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// centered_moving_average
// Centred moving average with windows clipped at both sequence ends.
// ----------------------------------------------------------------------------
// Input words (s_) carry one sample and a flag marking the sequence's last
// sample. Each result word (m_) carries the rounded mean of the samples
// within radius positions of one sequence position, plus run_last and
// sequence_end flags. The radius register is written through cfg_wr_en /
// cfg_wr_data; the user must write it only while the block is idle, as the
// block itself does not enforce this. Values above MAX_RADIUS are clamped.
// The front takes one word, then steps through the trim state (with a drop
// state for each surplus sample), the write and decide states, and then
// queues the divide jobs, one per result, with a check state and, where a
// held sample is dropped, a drop state before each flushed result after it.
// The back divides in DIV_STEPS quotient bits per cycle over the full
// dividend width whatever the radius register holds, and takes another
// job only once the last result is loaded into the output register.
// A stalled receiver holds the output register; the back then stops, the
// four-entry job queue fills and the front stops taking words.
// Reset clears the sums and counters, sets the radius to 1 and empties
// the queue and output; the sample store needs no clearing.
// ----------------------------------------------------------------------------
module centered_moving_average
    import cma_pkg::*;
#(
    parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_wr_en,
    input  wire logic [RADIUS_BITS-1:0] cfg_wr_data,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire cma_in_t                s_data,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output cma_out_t                    m_data
);

    localparam int CNT_W  = $clog2(2*MAX_RADIUS+2);
    localparam int SUM_W  = SAMPLE_BITS + CNT_W;
    localparam int JOB_W  = SUM_W + CNT_W + 2;

    logic [RADIUS_BITS-1:0] radius_reg, radius_next;

    cma_q_status_t     q_status;
    logic              push;
    logic              pop;
    logic [SUM_W-1:0]  push_sum;
    logic [CNT_W-1:0]  push_count;
    logic              push_last;
    logic              push_end;
    logic [JOB_W-1:0]  head;

    assign radius_next = cfg_wr_en ? cfg_wr_data : radius_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= RADIUS_RESET;
        end else begin
            radius_reg <= radius_next;
        end
    end

    cma_front #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .radius     (radius_reg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .q_status   (q_status),
        .push       (push),
        .push_sum   (push_sum),
        .push_count (push_count),
        .push_last  (push_last),
        .push_end   (push_end)
    );

    cma_queue #(
        .DATA_W (JOB_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data ({push_sum, push_count, push_last, push_end}),
        .pop       (pop),
        .pop_data  (head),
        .status    (q_status)
    );

    cma_back #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_status  (q_status),
        .job_sum   (head[JOB_W-1 -: SUM_W]),
        .job_count (head[CNT_W+1:2]),
        .job_last  (head[1]),
        .job_end   (head[0]),
        .pop       (pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
`default_nettype wire

### rtl/core/cma_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cma_checker
// Port-level checks of the centred moving average block, bound to the top.
// ----------------------------------------------------------------------------
module cma_checker
    import cma_pkg::*;
(
    input wire logic     aclk,
    input wire logic     aresetn,
    input wire logic     s_valid,
    input wire logic     s_ready,
    input wire logic     m_valid,
    input wire logic     m_ready,
    input wire cma_out_t m_data
);

    // no result word straight after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a held result keeps its word
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // one word at a time on the input side
    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready straight after a word was taken");

    // sequence end only on the last result of its word
    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.sequence_end |-> m_data.run_last)
        else $error("sequence end without run last");

    // ready only drops when a word is taken
    a_ready_fall: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |-> $past(s_valid))
        else $error("input ready dropped with no word taken");

endmodule

bind centered_moving_average cma_checker u_cma_checker (.*);
`default_nettype wire

### test/tb_centered_moving_average.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_centered_moving_average
// Self-checking bench for the edge-clipped centred moving average.
// ----------------------------------------------------------------------------
// Directed sequences cover the field extremes, rounding of halves in both
// signs, single-sample and short sequences, the radius extremes and a radius
// change part-way through a sequence. Random sequences then run under three
// idling patterns with several radius settings. A bit-level predictor runs on
// every accepted input word and every result word is compared with it.
// ----------------------------------------------------------------------------
module tb_centered_moving_average;
    import cma_pkg::*;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef sample_t sample_list_t [$];

    localparam int RING_DEPTH = 64;
    localparam int SETTLE_CYCLES = 150;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [RADIUS_BITS-1:0] cfg_wr_data = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    cma_in_t                s_data = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    cma_out_t               m_data;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches = 0;

    // predictor state
    int       model_radius;
    sample_t  ring_sample [RING_DEPTH];
    longint   ring_sum;
    int       ring_count;
    int       emitted_count;
    int       ring_wr;
    cma_out_t expected_words [$];

    centered_moving_average DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic void drop_oldest_sample();
        int slot;
        if (ring_count == 0) return;
        slot = (ring_wr - ring_count) & (RING_DEPTH - 1);
        ring_sum -= longint'(ring_sample[slot]);
        ring_count--;
    endfunction

    function automatic void emit_average(logic last, logic seq_end);
        cma_out_t word;
        longint   divisor;
        longint   mag;
        longint   quo;
        divisor = (ring_count != 0) ? ring_count : 1;
        mag = (ring_sum < 0) ? -ring_sum : ring_sum;
        quo = (mag + divisor / 2) / divisor;
        if (ring_sum < 0) quo = -quo;
        word.average = quo[SAMPLE_BITS-1:0];
        word.run_last = last;
        word.sequence_end = seq_end;
        expected_words = {expected_words, word};
        if (emitted_count < 127) emitted_count++;
    endfunction

    function automatic void predict_averages(cma_in_t w);
        int m;
        int pending;
        m = (model_radius > MAX_RADIUS_DEF) ? MAX_RADIUS_DEF : model_radius;
        while (ring_count >= 2 * m + 1 && ring_count > 0) drop_oldest_sample();
        ring_sample[ring_wr] = w.sample;
        ring_wr = (ring_wr + 1) & (RING_DEPTH - 1);
        ring_count++;
        ring_sum += longint'(w.sample);
        if (!w.final_sample) begin
            if (ring_count > m) emit_average(1'b1, 1'b0);
            return;
        end
        pending = (ring_count < m + 1) ? ring_count : m + 1;
        if (pending > MAX_OUT) pending = MAX_OUT;
        for (int k = 0; k < pending; k++) begin
            if (k > 0 && emitted_count > m && ring_count > 1) drop_oldest_sample();
            emit_average(k + 1 == pending, k + 1 == pending);
        end
        ring_sum = 0;
        ring_count = 0;
        emitted_count = 0;
        ring_wr = 0;
    endfunction

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // predictor on accepted input words, checker on result words
    always @(posedge aclk) begin
        cma_out_t want;
        if (aresetn) begin
            if (cfg_wr_en) model_radius = cfg_wr_data;
            if (s_valid && s_ready) predict_averages(s_data);
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word: average %0d run_last %0b seq_end %0b",
                                 m_data.average, m_data.run_last, m_data.sequence_end);
                end else begin
                    want = expected_words.pop_front();
                    if (m_data.average !== want.average || m_data.run_last !== want.run_last
                            || m_data.sequence_end !== want.sequence_end) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch at %0t: average %0d/%0d run_last %0b/%0b",
                                      " seq_end %0b/%0b (exp/act)"},
                                     $realtime, want.average, m_data.average,
                                     want.run_last, m_data.run_last,
                                     want.sequence_end, m_data.sequence_end);
                    end
                end
            end
        end
    end

    task automatic send_word(cma_in_t w);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= w;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_sequence(sample_list_t vals);
        cma_in_t w;
        foreach (vals[i]) begin
            w.sample = vals[i];
            w.final_sample = (i == vals.size() - 1);
            send_word(w);
        end
    endtask

    task automatic wait_until_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_words.size() != 0) @(posedge aclk);
        // non-final words may still be in the front with no result due
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_radius(int value);
        wait_until_idle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= RADIUS_BITS'(value);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    function automatic sample_t random_sample();
        case ($urandom_range(3))
            0: return $urandom_range(1) ? sample_t'(8388607) : sample_t'(-8388608);
            1: return sample_t'(int'($urandom_range(16)) - 8);
            default: return sample_t'($urandom);
        endcase
    endfunction

    // reset radius of one, full-scale words summed in both signs
    task automatic test_reset_radius();
        send_sequence('{8388607, 8388607, -8388608, -8388608});
    endtask

    task automatic test_single_sample();
        send_sequence('{-77});
    endtask

    // halves round away from zero in both signs
    task automatic test_rounding();
        send_sequence('{1, 2});
        send_sequence('{-1, -2});
    endtask

    task automatic test_radius_zero();
        write_radius(0);
        send_sequence('{8388607, -8388608, 7});
    endtask

    // sequence shorter than the window, clipped at both ends
    task automatic test_short_sequence();
        write_radius(5);
        send_sequence('{3, -8, 1000});
    endtask

    task automatic test_radius_max();
        write_radius(MAX_RADIUS_DEF);
        send_sequence('{-8388608, 8388607});
    endtask

    // radius shrinks while samples are held, surplus dropped oldest first
    task automatic test_radius_change();
        cma_in_t w;
        write_radius(2);
        w.final_sample = 1'b0;
        for (int i = 0; i < 4; i++) begin
            w.sample = sample_t'(100 * (i + 1));
            send_word(w);
        end
        write_radius(0);
        send_sequence('{-500, -600});
    endtask

    task automatic run_random_sequences(int radius, int budget);
        int      sent;
        int      len;
        cma_in_t w;
        sent = 0;
        while (sent < budget) begin
            if (radius == MAX_RADIUS_DEF && sent == 0)
                len = 40;   // enough held samples for the longest flush
            else if ($urandom_range(7) == 0)
                len = $urandom_range(2 * radius + 4, 2 * radius + 1);
            else
                len = $urandom_range(radius + 3, 1);
            for (int i = 0; i < len; i++) begin
                w.sample = random_sample();
                w.final_sample = (i == len - 1);
                send_word(w);
            end
            sent += len;
        end
    endtask

    task automatic test_random_sequences();
        int setting;
        int radius;
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: set_idling(9, 76);
                1: set_idling(76, 9);
                default: set_idling(0, 0);
            endcase
            for (int j = 0; j < 2; j++) begin
                setting = phase * 2 + j;
                case (setting)
                    0: radius = MAX_RADIUS_DEF;
                    3: radius = 0;
                    5: radius = 1;
                    default: radius = $urandom_range(31);
                endcase
                write_radius(radius);
                run_random_sequences(radius, 5);
            end
        end
    endtask

    initial begin
        model_radius = RADIUS_RESET;
        ring_sum = 0;
        ring_count = 0;
        emitted_count = 0;
        ring_wr = 0;
        aresetn <= 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_idling(9, 76);
        test_reset_radius();
        test_single_sample();
        test_rounding();
        test_radius_zero();
        test_short_sequence();
        test_radius_max();
        test_radius_change();
        test_random_sequences();

        wait_until_idle();
        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
